// ===== hdl/eids_pkg.sv =====
package eids_pkg;

    localparam int EntriesPerPage = 64;
    localparam int PageSlots      = 16;
    localparam int IdBits         = 5 + 64 + 64 + 32;
    localparam int TimeBits       = 48;

    typedef enum logic [0:0] {
        MODE_ADD    = 1'b0,
        MODE_LOOKUP = 1'b1
    } t_mode;

    typedef struct packed {
        logic [4:0]  len;
        logic [63:0] w0;
        logic [63:0] w1;
        logic [31:0] w2;
    } t_id;

    typedef struct packed {
        logic       hit;
        logic [1:0] kind;
    } t_match;

    // Compare a stored identifier against a key on length and leading bytes.
    function automatic logic id_match(t_id a, t_id b);
        logic [159:0] bits_a;
        logic [159:0] bits_b;
        logic         ok;
        bits_a = {a.w0, a.w1, a.w2};
        bits_b = {b.w0, b.w1, b.w2};
        ok = (a.len == b.len);
        for (int i = 0; i < 20; i++) begin
            if (i < int'(b.len) && bits_a[159 - 8*i -: 8] != bits_b[159 - 8*i -: 8]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// ===== hdl/eids_if.sv =====
interface eids_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [4:0]  id_length;
    logic [63:0] id_bytes_first;
    logic [63:0] id_bytes_middle;
    logic [31:0] id_bytes_last;
    logic [1:0]  kind_code;
    logic [47:0] now_time;
    modport source (output valid, mode, id_length, id_bytes_first, id_bytes_middle,
                    id_bytes_last, kind_code, now_time, input ready);
    modport sink (input valid, mode, id_length, id_bytes_first, id_bytes_middle,
                  id_bytes_last, kind_code, now_time, output ready);
endinterface

interface eids_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [1:0] found_kind;
    logic       dropped;
    modport source (output valid, found, found_kind, dropped, input ready);
    modport sink (input valid, found, found_kind, dropped, output ready);
endinterface

interface eids_cfg_if;
    logic        valid;
    logic        ready;
    logic [47:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== hdl/eids_ram.sv =====
module eids_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/eids_cell.sv =====
// One compare cell of the page scan. Each cell owns one page: it compares
// the entry read from its page against the key, and passes on the match at
// its i_prev input in preference to its own.
module eids_cell
    import eids_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_clear,
    input  logic   i_live,
    input  t_id    i_key,
    input  t_id    i_entry,
    input  logic [1:0] i_kind,
    input  t_match i_prev,
    output t_match o_next
);
    t_match r_best;
    t_match n_best;

    always_comb begin
        n_best = r_best;
        if (i_clear) begin
            n_best = '0;
        end else if (!r_best.hit && i_live && id_match(i_entry, i_key)) begin
            n_best.hit  = 1'b1;
            n_best.kind = i_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else begin
            r_best <= n_best;
        end
    end

    assign o_next = i_prev.hit ? i_prev : r_best;
endmodule

// ===== hdl/expiring_id_set_paged.sv =====
// An add passes through S_ADD, then S_EXPIRE releases expired pages one per
// cycle; an add dropped on a full ring goes from S_ADD straight to S_DONE.
// A lookup steps through S_SCAN and then S_DONE: every page has its own RAM and
// compare cell, so all pages are scanned in parallel, one entry per page per
// cycle, and the oldest page with a match supplies the result.
// One item is in work at a time; the result register frees the input side.
// Reset (synchronous, active low) empties the ring and clears min_lifetime.
module expiring_id_set_paged
    import eids_pkg::*;
#(
    parameter int ENTRIES_PER_PAGE = EntriesPerPage,
    parameter int PAGE_SLOTS       = PageSlots
) (
    input  logic i_clk,
    input  logic i_rst_n,
    eids_cfg_if.sink   cfg,
    eids_in_if.sink    in_ch,
    eids_out_if.source out_ch
);
    localparam int EW = $clog2(ENTRIES_PER_PAGE);
    localparam int PW = $clog2(PAGE_SLOTS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ADD    = 5'b00010,
        S_EXPIRE = 5'b00100,
        S_SCAN   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [47:0]   r_min_life;
    logic [PW-1:0] r_oldest;
    logic [PW:0]   r_in_use;
    logic [EW:0]   r_fill;
    logic [47:0]   r_stamp [PAGE_SLOTS];
    t_id           r_key;
    logic [1:0]    r_kind;
    logic [47:0]   r_now;
    logic          r_mode;
    logic [EW:0]   r_cnt;
    logic          r_add_drop;
    logic          r_oval, r_found, r_dropped;
    logic [1:0]    r_fkind;

    // Configuration is never refused; the user must let it arrive only in idle.
    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_life <= '0;
        end else if (cfg.valid) begin
            r_min_life <= cfg.data;
        end
    end

    // A new item may start while the previous result still waits; it then
    // holds in its last state until the result register is free.
    assign in_ch.ready = (r_state == S_IDLE);
    wire in_xfer  = in_ch.valid && in_ch.ready;
    wire out_free = !r_oval || out_ch.ready;

    // Add bookkeeping: page that will receive the entry.
    wire need_page = (r_in_use == '0) || (r_fill == (EW+1)'(ENTRIES_PER_PAGE));
    wire full_ring = need_page && (r_in_use == (PW+1)'(PAGE_SLOTS));
    logic [PW:0] newest_sum;
    logic [PW-1:0] newest_pg;
    logic [PW:0] use_after;
    always_comb begin
        use_after  = need_page ? r_in_use + 1'b1 : r_in_use;
        newest_sum = (PW+1)'(r_oldest) + use_after - 1'b1;
        newest_pg  = (newest_sum >= (PW+1)'(PAGE_SLOTS)) ?
                     PW'(newest_sum - (PW+1)'(PAGE_SLOTS)) : newest_sum[PW-1:0];
    end
    wire [EW-1:0] wr_slot = need_page ? '0 : r_fill[EW-1:0];
    wire          add_we  = (r_state == S_ADD) && !full_ring;

    // Expiry test of the oldest page, one page per cycle.
    wire [48:0] exp_sum = {1'b0, r_stamp[r_oldest]} + {1'b0, r_min_life};
    wire oldest_full = (r_in_use > (PW+1)'(1)) || (r_fill == (EW+1)'(ENTRIES_PER_PAGE));
    wire expire = (r_in_use != '0) && oldest_full && (exp_sum < {1'b0, r_now});

    // Per-page RAMs and compare cells, indexed by physical page.
    logic [PW-1:0] page_age [PAGE_SLOTS];
    t_match        cell_out [PAGE_SLOTS];
    t_match        scan_hit;
    wire [EW-1:0] rd_addr = r_cnt[EW-1:0];

    for (genvar p = 0; p < PAGE_SLOTS; p++) begin : g_page
        logic [IdBits+1:0] rdata;
        logic [PW:0]       pos_sum;
        logic [PW-1:0]     age;
        logic              live;
        logic              r_live;
        assign pos_sum = (PW+1)'(p) + (PW+1)'(PAGE_SLOTS) - (PW+1)'(r_oldest);
        assign age = (pos_sum >= (PW+1)'(PAGE_SLOTS)) ?
                     PW'(pos_sum - (PW+1)'(PAGE_SLOTS)) : pos_sum[PW-1:0];
        assign page_age[p] = age;
        always_comb begin
            live = 1'b0;
            if ((PW+1)'(age) < r_in_use) begin
                if ((PW+1)'(age) + 1'b1 == r_in_use) begin
                    live = r_cnt < r_fill;
                end else begin
                    live = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_live <= 1'b0;
            end else begin
                r_live <= live && (r_state == S_SCAN) &&
                          (r_cnt < (EW+1)'(ENTRIES_PER_PAGE));
            end
        end
        eids_ram #(.Width(IdBits + 2), .Depth(ENTRIES_PER_PAGE)) u_ram (
            .i_clk  (i_clk),
            .i_we   (add_we && newest_pg == PW'(p)),
            .i_waddr(wr_slot),
            .i_wdata({r_key, r_kind}),
            .i_raddr(rd_addr),
            .o_rdata(rdata)
        );
        eids_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_clear(in_xfer),
            .i_live (r_live),
            .i_key  (r_key),
            .i_entry(rdata[IdBits+1:2]),
            .i_kind (rdata[1:0]),
            .i_prev ('0),
            .o_next (cell_out[p])
        );
    end

    // Ordered by age, not by physical page: the oldest page with a hit wins.
    always_comb begin
        scan_hit = '0;
        for (int a = 0; a < PAGE_SLOTS; a++) begin
            for (int q = 0; q < PAGE_SLOTS; q++) begin
                if (!scan_hit.hit && page_age[q] == PW'(a) && cell_out[q].hit) begin
                    scan_hit = cell_out[q];
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_xfer) n_state = in_ch.mode ? S_SCAN : S_ADD;
            S_ADD:    n_state = full_ring ? S_DONE : S_EXPIRE;
            S_EXPIRE: if (!expire) n_state = S_DONE;
            S_SCAN:   if (r_cnt == (EW+1)'(ENTRIES_PER_PAGE + 1)) n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_key  <= '{len: in_ch.id_length, w0: in_ch.id_bytes_first,
                        w1: in_ch.id_bytes_middle, w2: in_ch.id_bytes_last};
            r_kind <= in_ch.kind_code;
            r_now  <= in_ch.now_time;
            r_mode <= in_ch.mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_oldest   <= '0;
            r_in_use   <= '0;
            r_fill     <= '0;
            r_cnt      <= '0;
            r_add_drop <= 1'b0;
            r_oval     <= 1'b0;
            r_found    <= 1'b0;
            r_fkind    <= '0;
            r_dropped  <= 1'b0;
            for (int i = 0; i < PAGE_SLOTS; i++) r_stamp[i] <= '0;
        end else begin
            r_state <= n_state;
            if (out_ch.ready && r_state != S_DONE) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                end
                S_ADD: begin
                    r_add_drop <= full_ring;
                    if (!full_ring) begin
                        r_in_use <= use_after;
                        r_fill   <= (EW+1)'(wr_slot) + 1'b1;
                        r_stamp[newest_pg] <=
                            ((EW+1)'(wr_slot) + 1'b1 == (EW+1)'(ENTRIES_PER_PAGE)) ?
                            r_now : '0;
                    end
                end
                S_EXPIRE: begin
                    if (expire) begin
                        r_oldest <= (r_oldest == PW'(PAGE_SLOTS - 1)) ? '0 : r_oldest + 1'b1;
                        r_in_use <= r_in_use - 1'b1;
                        if (r_in_use == (PW+1)'(1)) r_fill <= '0;
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_oval    <= 1'b1;
                        r_found   <= r_mode && scan_hit.hit;
                        r_fkind   <= (r_mode && scan_hit.hit) ? scan_hit.kind : '0;
                        r_dropped <= !r_mode && r_add_drop;
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_ch.valid      = r_oval;
    assign out_ch.found      = r_found;
    assign out_ch.found_kind = r_fkind;
    assign out_ch.dropped    = r_dropped;

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !in_ch.ready) else $error("input taken while busy");
    a_use_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_use <= (PW+1)'(PAGE_SLOTS)) else $error("page count overflow");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (EW+1)'(ENTRIES_PER_PAGE)) else $error("fill overflow");
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval && !r_found |-> r_fkind == '0) else $error("kind without match");
endmodule

// ===== bench/expiring_id_set_paged_test.sv =====
`timescale 1ns / 100ps

// Checks the paged connection-ID set against its own behavioral model in this
// bench: adds, lookups, page expiry and lifetime settings.
module expiring_id_set_paged_test
    import eids_pkg::*;
();

    localparam int Epp = EntriesPerPage;
    localparam int Slots = PageSlots;
    localparam int WatchLimit = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    eids_cfg_if cfg_ch ();
    eids_in_if in_ch ();
    eids_out_if out_ch ();

    expiring_id_set_paged dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .cfg    (cfg_ch.sink),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // One stimulus item, as driven onto the input channel.
    typedef struct packed {
        t_mode       mode;
        logic [4:0]  len;
        logic [63:0] w0;
        logic [63:0] w1;
        logic [31:0] w2;
        logic [1:0]  kind;
        logic [47:0] now;
    } t_item;

    typedef struct packed {
        logic       found;
        logic [1:0] kind;
        logic       dropped;
    } t_result;

    // Directed rows: a flag says whether the typed result is used or the
    // predictor supplies it.
    typedef struct {
        t_item   item;
        bit      typed;
        t_result res;
    } t_row;

    // Model state of the ID store.
    logic [63:0] ids_w0 [Slots*Epp];
    logic [63:0] ids_w1 [Slots*Epp];
    logic [31:0] ids_w2 [Slots*Epp];
    logic [4:0]  ids_len [Slots*Epp];
    logic [1:0]  ids_kind [Slots*Epp];
    logic [47:0] stamp_of_page [Slots];
    int          oldest_pg;
    int          pages_used;
    int          fill_newest;
    logic [47:0] lifetime;

    t_result pending_results[$];
    int      mismatches = 0;
    int      idle_cycles = 0;
    bit      idle_on;

    function automatic int entries_in(int k);
        return (k + 1 == pages_used) ? fill_newest : Epp;
    endfunction

    function automatic bit bytes_equal(t_item a, int s);
        logic [159:0] ka;
        logic [159:0] kb;
        ka = {a.w0, a.w1, a.w2};
        kb = {ids_w0[s], ids_w1[s], ids_w2[s]};
        if (ids_len[s] != a.len) return 1'b0;
        for (int i = 0; i < 20; i++) begin
            if (i < int'(a.len) && ka[159 - 8*i -: 8] != kb[159 - 8*i -: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one item to the model and return the result it should produce.
    function automatic t_result apply_item(t_item it);
        t_result r;
        int pg;
        int s;
        r = '0;
        if (it.mode == MODE_ADD) begin
            if (pages_used == 0 || fill_newest >= Epp) begin
                if (pages_used >= Slots) begin
                    r.dropped = 1'b1;
                    return r;
                end
                pages_used++;
                fill_newest = 0;
                stamp_of_page[(oldest_pg + pages_used - 1) % Slots] = '0;
            end
            pg = (oldest_pg + pages_used - 1) % Slots;
            s = pg * Epp + fill_newest;
            ids_w0[s] = it.w0;
            ids_w1[s] = it.w1;
            ids_w2[s] = it.w2;
            ids_len[s] = it.len;
            ids_kind[s] = it.kind;
            fill_newest++;
            if (fill_newest >= Epp) stamp_of_page[pg] = it.now;
            // The expiry sum is 49 bits wide so it never wraps.
            while (pages_used > 0 && entries_in(0) >= Epp &&
                   ({1'b0, stamp_of_page[oldest_pg]} + {1'b0, lifetime}) < {1'b0, it.now}) begin
                oldest_pg = (oldest_pg + 1) % Slots;
                pages_used--;
            end
            if (pages_used == 0) fill_newest = 0;
        end else begin
            for (int k = 0; k < pages_used; k++) begin
                for (int i = 0; i < entries_in(k); i++) begin
                    s = ((oldest_pg + k) % Slots) * Epp + i;
                    if (bytes_equal(it, s)) begin
                        r.found = 1'b1;
                        r.kind = ids_kind[s];
                        return r;
                    end
                end
            end
        end
        return r;
    endfunction

    // Idle roughly 15 percent of cycles, except in the no-idle stretch.
    function automatic bit take_gap();
        return idle_on && ($urandom_range(99) < 15);
    endfunction

    // Keep a small ID pool so lookups hit and duplicates occur.
    t_item id_pool[$];
    logic [47:0] clock_us;

    function automatic t_item random_item(bit adds_only);
        t_item it;
        it.w0 = {$urandom, $urandom};
        it.w1 = {$urandom, $urandom};
        it.w2 = $urandom;
        it.len = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(20));
        it.kind = 2'($urandom_range(3));
        it.mode = (adds_only || $urandom_range(2) == 0) ? MODE_LOOKUP : MODE_ADD;
        it.mode = adds_only ? MODE_ADD : it.mode;
        if (it.mode == MODE_LOOKUP && id_pool.size() > 0 && $urandom_range(3) != 0) begin
            it = id_pool[$urandom_range(id_pool.size() - 1)];
            it.mode = MODE_LOOKUP;
            // Sometimes disturb the last byte, which matters only at a length of 20 or more.
            if ($urandom_range(3) == 0) it.w2[7:0] = ~it.w2[7:0];
        end
        clock_us = clock_us + 48'($urandom_range(40));
        if ($urandom_range(49) == 0) clock_us = 48'({$urandom, $urandom});
        it.now = clock_us;
        if (it.mode == MODE_ADD) begin
            id_pool.push_back(it);
            if (id_pool.size() > 40) void'(id_pool.pop_front());
        end
        return it;
    endfunction

    // Send one item; the expected result is queued at the moment of transfer.
    // Valid stays high into the next call, which drops it during a gap.
    task automatic send_item(t_item it, bit typed, t_result res);
        t_result want;
        while (take_gap()) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= it.mode;
        in_ch.id_length <= it.len;
        in_ch.id_bytes_first <= it.w0;
        in_ch.id_bytes_middle <= it.w1;
        in_ch.id_bytes_last <= it.w2;
        in_ch.kind_code <= it.kind;
        in_ch.now_time <= it.now;
        do @(posedge i_clk); while (!in_ch.ready);
        want = apply_item(it);
        pending_results.push_back(typed ? res : want);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() > 0) @(negedge i_clk);
        // Idle a while so the next phase starts from quiet channels.
        repeat (3 * Slots + 8) @(negedge i_clk);
    endtask

    task automatic write_lifetime(logic [47:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        lifetime = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: random stalls, in-order compare against the oldest expectation.
    always @(negedge i_clk) begin
        out_ch.ready <= !take_gap();
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.found, out_ch.found_kind, out_ch.dropped};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Watchdog over cycles with no transfer on any channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchLimit) begin
            $display("** expiring_id_set_paged: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    t_row rows[$];

    task automatic add_row(t_mode m, logic [4:0] len, logic [63:0] w0, logic [63:0] w1,
                           logic [31:0] w2, logic [1:0] kind, logic [47:0] now,
                           bit typed, t_result res);
        t_row r;
        r.item = '{m, len, w0, w1, w2, kind, now};
        r.typed = typed;
        r.res = res;
        rows.push_back(r);
    endtask

    initial begin
        t_item it;
        idle_on = 1'b1;
        lifetime = '0;
        oldest_pg = 0;
        pages_used = 0;
        fill_newest = 0;
        clock_us = '0;
        foreach (stamp_of_page[i]) stamp_of_page[i] = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_ADD;
        in_ch.id_length = '0;
        in_ch.id_bytes_first = '0;
        in_ch.id_bytes_middle = '0;
        in_ch.id_bytes_last = '0;
        in_ch.kind_code = '0;
        in_ch.now_time = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. A lookup on the empty set misses; then extremes of
        // every field, zero length, length above 20, and don't-care bytes.
        add_row(MODE_LOOKUP, 5'd0, '0, '0, '0, 2'd0, '0, 1, '{1'b0, 2'd0, 1'b0});
        add_row(MODE_ADD, 5'd20, '1, '1, '1, 2'd3, '1, 1, '0);
        add_row(MODE_LOOKUP, 5'd20, '1, '1, '1, 2'd0, '0, 1, '{1'b1, 2'd3, 1'b0});
        add_row(MODE_LOOKUP, 5'd19, '1, '1, '1, 2'd0, '0, 1, '{1'b0, 2'd0, 1'b0});
        add_row(MODE_ADD, 5'd0, 64'h0123_4567_89AB_CDEF, '0, '0, 2'd2, '0, 1, '0);
        add_row(MODE_LOOKUP, 5'd0, '1, '1, '1, 2'd1, '1, 1, '{1'b1, 2'd2, 1'b0});
        add_row(MODE_ADD, 5'd31, 64'hA5A5_A5A5_A5A5_A5A5, '0, 32'h5A5A_5A5A, 2'd1, 48'd5, 1, '0);
        add_row(MODE_LOOKUP, 5'd31, 64'hA5A5_A5A5_A5A5_A5A5, '0, 32'h5A5A_5A5A, 2'd0, '0, 1,
                '{1'b1, 2'd1, 1'b0});
        add_row(MODE_ADD, 5'd3, 64'hDEAD_BE00_0000_0000, '1, '1, 2'd0, 48'd9, 1, '0);
        add_row(MODE_LOOKUP, 5'd3, 64'hDEAD_BEFF_FFFF_FFFF, '0, '0, 2'd3, '0, 0, '0);
        add_row(MODE_LOOKUP, 5'd3, 64'hDEAD_BF00_0000_0000, '0, '0, 2'd3, '0, 0, '0);
        add_row(MODE_ADD, 5'd12, '0, 64'h1122_3344_0000_0000, '0, 2'd1, '1, 0, '0);
        add_row(MODE_LOOKUP, 5'd12, '0, 64'h1122_3344_FFFF_FFFF, '1, 2'd0, '0, 0, '0);
        foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].res);
        drain();

        // With the longest lifetime nothing expires: a stretch of adds with
        // no idling fills several pages back to back.
        write_lifetime('1);
        idle_on = 1'b0;
        for (int n = 0; n < 150; n++) send_item(random_item(1), 0, '0);
        idle_on = 1'b1;
        drain();

        // Random phases under different lifetimes, zero among them; steady
        // adds let full pages expire.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: write_lifetime('0);
                1: write_lifetime(48'd300);
                default: write_lifetime(48'd5);
            endcase
            for (int n = 0; n < 140; n++) send_item(random_item(0), 0, '0);
            drain();
        end

        if (mismatches == 0) begin
            $display("** expiring_id_set_paged: PASSED **");
        end else begin
            $display("** expiring_id_set_paged: FAILED **");
        end
        $finish;
    end
endmodule

// ===== expiring_id_set_paged.f =====
hdl/eids_pkg.sv
hdl/eids_if.sv
hdl/eids_ram.sv
hdl/eids_cell.sv
hdl/expiring_id_set_paged.sv
bench/expiring_id_set_paged_test.sv
